// File: design/ifla_pkg.sv
// Shared constants, codes and types of the slot identifier allocator.
`default_nettype none
package ifla_pkg;

  localparam int CAPACITY   = 1024;
  localparam int MIN_GROWTH = 64;
  localparam int ID_W       = 10;
  localparam int CNT_W      = $clog2(CAPACITY) + 1;
  localparam int DATA_W     = 16;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_USED  = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic             ok;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] size;
  } fresh_t;

endpackage
`default_nettype wire

// File: design/ifla_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ifla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/ifla_fresh.sv
// Fresh identifier source: table size, growth and the current count-down batch.
`default_nettype none
module ifla_fresh
  import ifla_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic take,
  output fresh_t    fresh
);

  logic [CNT_W-1:0] table_size;
  logic [ID_W-1:0]  fresh_next;
  logic [ID_W-1:0]  fresh_floor;

  logic             batch_empty;
  logic             can_grow;
  logic [CNT_W:0]   doubled;
  logic [CNT_W:0]   grown;
  logic [ID_W-1:0]  eff_next;
  logic [ID_W-1:0]  eff_floor;

  always_comb begin
    batch_empty = (fresh_floor == '0) || (fresh_next < fresh_floor);
    can_grow    = table_size < CNT_W'(CAPACITY);
    doubled     = {table_size, 1'b0};
    grown       = doubled;
    if (grown < (CNT_W+1)'(MIN_GROWTH)) begin
      grown = (CNT_W+1)'(MIN_GROWTH);
    end
    if (grown > (CNT_W+1)'(CAPACITY)) begin
      grown = (CNT_W+1)'(CAPACITY);
    end
    if (batch_empty) begin
      eff_next  = ID_W'(grown - (CNT_W+1)'(1));
      eff_floor = (table_size == '0) ? ID_W'(1) : table_size[ID_W-1:0];
    end else begin
      eff_next  = fresh_next;
      eff_floor = fresh_floor;
    end
    fresh.ok   = !batch_empty || can_grow;
    fresh.id   = eff_next;
    fresh.size = table_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size  <= '0;
      fresh_next  <= '0;
      fresh_floor <= '0;
    end else if (take && fresh.ok) begin
      if (batch_empty) begin
        table_size <= grown[CNT_W-1:0];
      end
      if (eff_next <= eff_floor) begin
        fresh_floor <= '0;
        fresh_next  <= eff_next;
      end else begin
        fresh_floor <= eff_floor;
        fresh_next  <= eff_next - ID_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/id_free_list_allocator.sv
// Top level of the slot identifier allocator: control, free stack and in-use map.
// An accepted item goes from S_IDLE to S_EXEC, where its result is registered
//   once the output register is free; no new item is taken until then, since the
//   stack and in-use memories are read before each read-modify-write.
// Reset: synchronous; afterwards the in-use map is swept to zero across all
//   CAPACITY addresses, during which s_tready stays low.
`default_nettype none
module id_free_list_allocator
  import ifla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,  // [1:0] op, [11:2] slot_id, [15:12] zero
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [DATA_W-1:0] m_tdata   // [1:0] status, [11:2] granted_id, [15:12] zero
);

  localparam int ADDR_W = $clog2(CAPACITY);

  state_t           state;
  state_t           state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]       op;
  logic [ID_W-1:0]  slot_id;
  logic [CNT_W-1:0] stack_count;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [ID_W-1:0]  out_id;

  logic             accept;
  logic             exec_go;
  logic             clearing;

  logic [ADDR_W-1:0] map_raddr;
  logic             map_rdata;
  logic             map_we;
  logic [ADDR_W-1:0] map_waddr;
  logic             map_wdata;
  logic [ADDR_W-1:0] stk_raddr;
  logic [ID_W-1:0]  stk_rdata;
  logic             stk_we;

  fresh_t           fresh;
  logic             fresh_take;
  logic             stack_empty;
  logic [1:0]       res_status;
  logic [ID_W-1:0]  res_id;
  logic             res_map_we;
  logic             res_map_bit;
  logic [ADDR_W-1:0] res_map_addr;
  logic             res_push;
  logic             res_pop;

  ifla_fresh u_fresh (
    .clk   (clk),
    .rst   (rst),
    .take  (fresh_take),
    .fresh (fresh)
  );

  ifla_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  ifla_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stack_count[ADDR_W-1:0]),
    .wdata (slot_id),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    clearing = (state == S_CLEAR);
    exec_go  = (state == S_EXEC) && (!out_valid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_comb begin
    stack_empty  = (stack_count == '0);
    res_status   = ST_OK;
    res_id       = slot_id;
    res_map_we   = 1'b0;
    res_map_bit  = 1'b0;
    res_map_addr = slot_id;
    res_push     = 1'b0;
    res_pop      = 1'b0;
    fresh_take   = 1'b0;
    priority if (op == OP_ALLOC) begin
      if (!stack_empty) begin
        res_id  = stk_rdata;
        res_pop = 1'b1;
      end else begin
        fresh_take = exec_go;
        res_id     = fresh.id;
      end
      if (stack_empty && !fresh.ok) begin
        res_status = ST_EXHAUSTED;
        res_id     = '0;
      end else begin
        res_map_we   = 1'b1;
        res_map_bit  = 1'b1;
        res_map_addr = res_id;
      end
    end else if (op == OP_FREE || op == OP_LOOKUP) begin
      if (slot_id == '0) begin
        res_status = ST_NOT_USED;
      end else if ({1'b0, slot_id} >= fresh.size) begin
        res_status = ST_RANGE;
      end else if (!map_rdata) begin
        res_status = ST_NOT_USED;
      end else if (op == OP_FREE) begin
        res_map_we = 1'b1;
        res_push   = (stack_count < CNT_W'(CAPACITY));
      end
    end else begin
      res_status = ST_RANGE;
    end
  end

  always_comb begin
    map_raddr = (state == S_IDLE) ? s_tdata[ID_W+1:2] : slot_id;
    stk_raddr = ADDR_W'(stack_count - CNT_W'(1));
    stk_we    = exec_go && res_push;
    if (clearing) begin
      map_we    = 1'b1;
      map_waddr = clr_addr;
      map_wdata = 1'b0;
    end else begin
      map_we    = exec_go && res_map_we;
      map_waddr = res_map_addr;
      map_wdata = res_map_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      stack_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (exec_go) begin
        out_valid <= 1'b1;
        if (res_pop) begin
          stack_count <= stack_count - CNT_W'(1);
        end else if (res_push) begin
          stack_count <= stack_count + CNT_W'(1);
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= s_tdata[1:0];
      slot_id <= s_tdata[ID_W+1:2];
    end
    if (exec_go) begin
      out_status <= res_status;
      out_id     <= res_id;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(DATA_W-ID_W-2)'(0), out_id, out_status};

endmodule
`default_nettype wire
